@@ rtl/strided_array_address_generator_top_macros.svh @@
// assertion macros shared by the address generator checker
// no dependencies
`ifndef STRIDED_ARRAY_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define STRIDED_ARRAY_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define SAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/sag_pkg.sv @@
// constants and types for the strided address generator
// no dependencies
`default_nettype none
package sag_pkg;
    localparam logic [1:0] OP_RAVEL = 2'd0;
    localparam logic [1:0] OP_COORD = 2'd1;
    localparam logic [1:0] OP_INDEX = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] REG_RANK = 3'd0;
    localparam logic [2:0] REG_SIZE0 = 3'd1;
    localparam logic [2:0] REG_SIZE1 = 3'd2;
    localparam logic [2:0] REG_SIZE2 = 3'd3;
    localparam logic [2:0] REG_STRIDE0 = 3'd4;
    localparam logic [2:0] REG_STRIDE1 = 3'd5;
    localparam logic [2:0] REG_STRIDE2 = 3'd6;
    localparam logic [2:0] REG_BASE = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] ravel_in;
        logic [15:0] coord_in_0;
        logic [15:0] coord_in_1;
        logic [15:0] coord_in_2;
    } t_in_word;

    typedef struct packed {
        logic [31:0] element_offset;
        logic [31:0] ravel_out;
        logic [15:0] coord_out_0;
        logic [15:0] coord_out_1;
        logic [15:0] coord_out_2;
        logic        is_solid;
    } t_out_word;

    // registered configuration seen by the datapath
    typedef struct packed {
        logic [1:0]  rank;
        logic [15:0] size_0;
        logic [15:0] size_1;
        logic [15:0] size_2;
        logic [31:0] stride_0;
        logic [31:0] stride_1;
        logic [31:0] stride_2;
        logic [30:0] base;
        logic        solid;
    } t_cfg;
endpackage
`default_nettype wire

@@ rtl/sag_if.sv @@
// valid/ready channel interface carrying one word
// depends on nothing but its type parameter
`default_nettype none
interface sag_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/strided_array_address_generator_top.sv @@
// Strided address generator: one word accepted per cycle through an input
// register, the pipelined ravel divider (four quotient bits per stage per axis,
// 24 stages) and multiply, sum and output stages. The whole pipeline advances
// together; it stalls only while a valid output word is not taken. Configure
// only while idle.
// depends on sag_pkg, sag_if, sag_cfg, sag_pipe
`default_nettype none
module strided_array_address_generator_top #(
    parameter int MAX_RANK = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    sag_if.sink              in_ch,
    sag_if.source            out_ch
);
    sag_pkg::t_cfg cfg;
    logic          en;
    logic          pv;

    sag_cfg #(.MAX_RANK(MAX_RANK)) u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_cfg(cfg)
    );

    // advance when the output slot is empty or being taken
    assign en = !pv || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = pv;

    sag_pipe u_pipe (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_en(en),
        .i_vld(in_ch.valid), .i_word(in_ch.data),
        .o_vld(pv), .o_word(out_ch.data)
    );
endmodule
`default_nettype wire

@@ rtl/sag_cfg.sv @@
// configuration registers and the solid flag
// depends on sag_pkg
`default_nettype none
module sag_cfg #(
    parameter int MAX_RANK = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    output sag_pkg::t_cfg          o_cfg
);
    logic [1:0]  r_rank;
    logic [15:0] r_size [3];
    logic [31:0] r_stride [3];
    logic [30:0] r_base;
    logic [15:0] e_size [3];
    logic [1:0]  eff_rank;
    logic [47:0] w1;
    logic        sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
            r_size[0] <= 16'd1;
            r_size[1] <= 16'd1;
            r_size[2] <= 16'd1;
            r_stride[0] <= '0;
            r_stride[1] <= '0;
            r_stride[2] <= 32'd1;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sag_pkg::REG_RANK:    r_rank <= i_cfg_data[1:0];
                sag_pkg::REG_SIZE0:   r_size[0] <= i_cfg_data[15:0];
                sag_pkg::REG_SIZE1:   r_size[1] <= i_cfg_data[15:0];
                sag_pkg::REG_SIZE2:   r_size[2] <= i_cfg_data[15:0];
                sag_pkg::REG_STRIDE0: r_stride[0] <= i_cfg_data;
                sag_pkg::REG_STRIDE1: r_stride[1] <= i_cfg_data;
                sag_pkg::REG_STRIDE2: r_stride[2] <= i_cfg_data;
                sag_pkg::REG_BASE:    r_base <= i_cfg_data[30:0];
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_size[i] = (r_size[i] == '0) ? 16'd1 : r_size[i];
        end
        eff_rank = (r_rank > 2'(MAX_RANK)) ? 2'(MAX_RANK) : r_rank;
        // dense weights checked from the fastest used axis outward
        sd = 1'b1;
        w1 = '0;
        unique case (eff_rank)
            2'd1: sd = (r_stride[0] == 32'd1);
            2'd2: begin
                sd = (r_stride[1] == 32'd1)
                    && (r_stride[0] == {16'd0, e_size[1]});
            end
            2'd3: begin
                w1 = {32'd0, e_size[2]} * {32'd0, e_size[1]};
                sd = (r_stride[2] == 32'd1)
                    && (r_stride[1] == {16'd0, e_size[2]})
                    && (w1[47:31] == '0) && (r_stride[0] == w1[31:0]);
            end
            default: sd = 1'b1;
        endcase
    end

    assign o_cfg = '{rank: eff_rank, size_0: e_size[0], size_1: e_size[1],
                     size_2: e_size[2], stride_0: r_stride[0],
                     stride_1: r_stride[1], stride_2: r_stride[2],
                     base: r_base, solid: sd};
endmodule
`default_nettype wire

@@ rtl/sag_divstage.sv @@
// one radix-2 step of a pipelined ravel divider
// depends on nothing
`default_nettype none
module sag_divstage (
    input  wire logic [31:0] i_rem,
    input  wire logic [30:0] i_quo,
    input  wire logic        i_bit,
    input  wire logic [15:0] i_div,
    output logic      [31:0] o_rem,
    output logic      [30:0] o_quo
);
    logic [32:0] sh;
    always_comb begin
        sh = {i_rem, i_bit};
        if (sh >= {17'd0, i_div}) begin
            o_rem = 32'(sh - {17'd0, i_div});
            o_quo = {i_quo[29:0], 1'b1};
        end else begin
            o_rem = sh[31:0];
            o_quo = {i_quo[29:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

@@ rtl/sag_pipe.sv @@
// stalled pipeline: ravel decode by restoring division, then offset and ravel
// depends on sag_pkg, sag_divstage
`default_nettype none
module sag_pipe (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sag_pkg::t_cfg     i_cfg,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire sag_pkg::t_in_word i_word,
    output logic                   o_vld,
    output sag_pkg::t_out_word     o_word
);
    // division stages: 3 axes x 31 bits, 4 bits per register stage
    localparam int BPS = 4;
    localparam int DST = (31 + BPS - 1) / BPS;
    localparam int NS = 3 * DST;
    localparam int L = NS + 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [30:0] num;
        logic [31:0] rem;
        logic [30:0] quo;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
    } t_st;

    t_st  r_st [NS+1];
    logic r_v [L+1];
    t_st  n_st [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        // axis of this stage, fastest first, and first dividend bit
        localparam logic [1:0] AX = 2'(2 - s / DST);
        localparam int POS = (s % DST) * BPS;
        localparam bit LAST = ((s % DST) == DST - 1);
        wire logic [31:0] rm [BPS+1];
        wire logic [30:0] qq [BPS+1];
        logic [15:0]      dv;
        logic             act;

        assign rm[0] = r_st[s].rem;
        assign qq[0] = r_st[s].quo;
        assign act = (r_st[s].op == sag_pkg::OP_RAVEL) && (i_cfg.rank > AX);
        assign dv = (AX == 2'd2) ? i_cfg.size_2
                  : (AX == 2'd1) ? i_cfg.size_1 : i_cfg.size_0;

        for (genvar b = 0; b < BPS; b++) begin : g_bit
            if (POS + b < 31) begin : g_live
                sag_divstage u_div (
                    .i_rem(rm[b]), .i_quo(qq[b]), .i_bit(r_st[s].num[30 - POS - b]),
                    .i_div(dv), .o_rem(rm[b+1]), .o_quo(qq[b+1])
                );
            end else begin : g_idle
                assign rm[b+1] = rm[b];
                assign qq[b+1] = qq[b];
            end
        end

        always_comb begin
            n_st[s] = r_st[s];
            if (act) begin
                n_st[s].rem = rm[BPS];
                n_st[s].quo = qq[BPS];
                if (LAST) begin
                    // pass done: store remainder, quotient feeds next axis
                    if (AX == 2'd2) n_st[s].c2 = rm[BPS][15:0];
                    else if (AX == 2'd1) n_st[s].c1 = rm[BPS][15:0];
                    else n_st[s].c0 = rm[BPS][15:0];
                    n_st[s].num = qq[BPS];
                    n_st[s].rem = '0;
                    n_st[s].quo = '0;
                end
            end
        end
    end

    logic [31:0] r_p0, r_p1, r_p2;
    logic [1:0]  r_op1, r_op2;
    logic [15:0] r_a0, r_a1, r_a2, r_b0, r_b1, r_b2;
    logic [31:0] r_z;
    logic [31:0] r_q0;
    logic [31:0] r_z2;
    logic [15:0] k0, k1, k2;
    logic [31:0] zz;

    always_comb begin
        k0 = (i_cfg.rank > 2'd0) ? r_st[NS].c0 : '0;
        k1 = (i_cfg.rank > 2'd1) ? r_st[NS].c1 : '0;
        k2 = (i_cfg.rank > 2'd2) ? r_st[NS].c2 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= L; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
            for (int s = 1; s <= L; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].op <= i_word.opcode;
            r_st[0].num <= i_word.ravel_in;
            r_st[0].rem <= '0;
            r_st[0].quo <= '0;
            r_st[0].c0 <= i_word.coord_in_0;
            r_st[0].c1 <= i_word.coord_in_1;
            r_st[0].c2 <= i_word.coord_in_2;
            for (int s = 0; s < NS; s++) r_st[s+1] <= n_st[s];
            // stage A: products (16 x 32 each, low word), ravel partial
            r_op1 <= r_st[NS].op;
            r_a0 <= k0; r_a1 <= k1; r_a2 <= k2;
            r_p0 <= {16'd0, k0} * i_cfg.stride_0;
            r_p1 <= {16'd0, k1} * i_cfg.stride_1;
            r_p2 <= {16'd0, k2} * i_cfg.stride_2;
            r_z <= {16'd0, k0} * {16'd0, i_cfg.size_1} + {16'd0, k1};
            // stage B: sum, finish ravel
            r_op2 <= r_op1;
            r_b0 <= r_a0; r_b1 <= r_a1; r_b2 <= r_a2;
            r_q0 <= {1'b0, i_cfg.base} + r_p0 + r_p1 + r_p2;
            r_z2 <= zz;
            // stage C: output mux
            o_word.is_solid <= i_cfg.solid;
            if (r_op2 == sag_pkg::OP_NONE) begin
                o_word.element_offset <= '0;
                o_word.ravel_out <= '0;
                o_word.coord_out_0 <= '0;
                o_word.coord_out_1 <= '0;
                o_word.coord_out_2 <= '0;
            end else begin
                o_word.element_offset <= r_q0;
                o_word.ravel_out <= (r_op2 == sag_pkg::OP_INDEX) ? r_z2 : '0;
                o_word.coord_out_0 <= r_b0;
                o_word.coord_out_1 <= r_b1;
                o_word.coord_out_2 <= r_b2;
            end
        end
    end

    always_comb begin
        unique case (i_cfg.rank)
            2'd1: zz = {16'd0, r_a0};
            2'd2: zz = r_z;
            2'd3: zz = r_z * {16'd0, i_cfg.size_2} + {16'd0, r_a2};
            default: zz = '0;
        endcase
    end

    assign o_vld = r_v[L];
endmodule
`default_nettype wire

@@ rtl/sag_checker.sv @@
// port-level checks on the address generator
// depends on the macros header and the top level
`default_nettype none
`include "strided_array_address_generator_top_macros.svh"
module sag_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic ir,
    input wire logic ov,
    input wire logic orr
);
    `SAG_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, ov && !orr, !ir)
    `SAG_ASSERT_IMPL(a_free_takes, i_clk, i_rst_n, !ov, ir)
    `SAG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, ov && !orr, ov)
endmodule
bind strided_array_address_generator_top sag_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .ir(in_ch.ready),
    .ov(out_ch.valid), .orr(out_ch.ready)
);
`default_nettype wire

@@ tb/sv/strided_array_address_generator_top_tb.sv @@
// self-checking testbench for the strided array address generator
// depends on sag_pkg, sag_if and strided_array_address_generator_top
`timescale 1ns / 1ps
`default_nettype none
module strided_array_address_generator_top_tb;

    localparam int LATENCY = 27;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    sag_if #(.T(sag_pkg::t_in_word)) in_ch ();
    sag_if #(.T(sag_pkg::t_out_word)) out_ch ();

    strided_array_address_generator_top #(.MAX_RANK(3)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the address registers
    logic [1:0] sh_rank;
    logic [15:0] sh_size[3];
    logic [31:0] sh_stride[3];
    logic [30:0] sh_base;

    sag_pkg::t_out_word addr_queue[$];
    int errors = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 64;
    bit recv_hold = 1'b0;
    int idle_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [31:0] eff_size(int i);
        return (sh_size[i] == 0) ? 32'd1 : {16'd0, sh_size[i]};
    endfunction

    function automatic sag_pkg::t_out_word predict_address(sag_pkg::t_in_word w);
        sag_pkg::t_out_word r;
        int rk;
        logic [31:0] c[3];
        logic [31:0] t;
        logic [31:0] acc;
        logic [31:0] z;
        logic signed [63:0] weight;
        logic solid;
        rk = (sh_rank > 3) ? 3 : sh_rank;
        c = '{0, 0, 0};
        acc = 0;
        z = 0;
        if (w.opcode == sag_pkg::OP_RAVEL) begin
            t = {1'b0, w.ravel_in};
            for (int k = rk; k > 0; k--) begin
                c[k-1] = t % eff_size(k-1);
                t = t / eff_size(k-1);
            end
        end else if (w.opcode == sag_pkg::OP_COORD || w.opcode == sag_pkg::OP_INDEX) begin
            if (rk > 0) c[0] = w.coord_in_0;
            if (rk > 1) c[1] = w.coord_in_1;
            if (rk > 2) c[2] = w.coord_in_2;
            if (w.opcode == sag_pkg::OP_INDEX && rk > 0) begin
                z = c[0];
                for (int i = 1; i < rk; i++) z = z * eff_size(i) + c[i];
            end
        end
        if (w.opcode != sag_pkg::OP_NONE) begin
            acc = {1'b0, sh_base};
            for (int i = 0; i < rk; i++) acc = acc + c[i] * sh_stride[i];
        end
        solid = 1'b1;
        weight = 1;
        for (int k = rk; k > 0; k--) begin
            if ($signed({{32{sh_stride[k-1][31]}}, sh_stride[k-1]}) != weight) solid = 1'b0;
            weight = weight * $signed({32'd0, eff_size(k-1)});
        end
        r.element_offset = acc;
        r.ravel_out = z;
        r.coord_out_0 = c[0][15:0];
        r.coord_out_1 = c[1][15:0];
        r.coord_out_2 = c[2][15:0];
        r.is_solid = solid;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            sag_pkg::REG_RANK: sh_rank = val[1:0];
            sag_pkg::REG_SIZE0: sh_size[0] = val[15:0];
            sag_pkg::REG_SIZE1: sh_size[1] = val[15:0];
            sag_pkg::REG_SIZE2: sh_size[2] = val[15:0];
            sag_pkg::REG_STRIDE0: sh_stride[0] = val;
            sag_pkg::REG_STRIDE1: sh_stride[1] = val;
            sag_pkg::REG_STRIDE2: sh_stride[2] = val;
            default: sh_base = val[30:0];
        endcase
    endtask

    task automatic set_view(logic [1:0] rk, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [31:0] t0, logic [31:0] t1,
                            logic [31:0] t2, logic [30:0] b);
        write_reg(sag_pkg::REG_RANK, {30'd0, rk});
        write_reg(sag_pkg::REG_SIZE0, {16'd0, s0});
        write_reg(sag_pkg::REG_SIZE1, {16'd0, s1});
        write_reg(sag_pkg::REG_SIZE2, {16'd0, s2});
        write_reg(sag_pkg::REG_STRIDE0, t0);
        write_reg(sag_pkg::REG_STRIDE1, t1);
        write_reg(sag_pkg::REG_STRIDE2, t2);
        write_reg(sag_pkg::REG_BASE, {1'b0, b});
    endtask

    // sender goes quiet, then waits for every expected word
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (addr_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // offers one word, expectation pushed when it is taken; valid stays up
    task automatic send_word(sag_pkg::t_in_word w, bit honor_idle);
        while (honor_idle && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        addr_queue.push_back(predict_address(w));
        @(negedge i_clk);
    endtask

    function automatic sag_pkg::t_in_word rand_word(int max_c);
        sag_pkg::t_in_word w;
        w.opcode = ($urandom_range(19) == 0) ? sag_pkg::OP_NONE : 2'($urandom_range(2));
        w.ravel_in = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(4000));
        w.coord_in_0 = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(max_c));
        w.coord_in_1 = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(max_c));
        w.coord_in_2 = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(max_c));
        return w;
    endfunction

    // receiver: ready changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (addr_queue.size() == 0) begin
                $display("%0t: unexpected word %h", $time, out_ch.data);
                errors++;
            end else begin
                sag_pkg::t_out_word e;
                e = addr_queue.pop_front();
                if (out_ch.data !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, out_ch.data);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("strided_array_address_generator_top_tb: FAIL");
            $finish;
        end
    end

    typedef struct {
        sag_pkg::t_in_word w;
        bit known;
        sag_pkg::t_out_word exp_word;
    } t_row;

    t_row reset_rows[4];
    t_row view_rows[$];

    initial begin
        sh_rank = 0;
        sh_size = '{1, 1, 1};
        sh_stride = '{0, 0, 1};
        sh_base = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // rank zero after reset: base offset, zero coordinates, solid
        reset_rows[0] = '{'{sag_pkg::OP_RAVEL, 31'h7fffffff, 16'd0, 16'd0, 16'd0}, 1'b1,
                          '{32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1}};
        reset_rows[1] = '{'{sag_pkg::OP_COORD, 31'd0, 16'hffff, 16'hffff, 16'hffff}, 1'b1,
                          '{32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1}};
        reset_rows[2] = '{'{sag_pkg::OP_INDEX, 31'd5, 16'd3, 16'd4, 16'd5}, 1'b1,
                          '{32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1}};
        reset_rows[3] = '{'{sag_pkg::OP_NONE, 31'h7fffffff, 16'hffff, 16'hffff, 16'hffff},
                          1'b1, '{32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1}};
        foreach (reset_rows[i]) begin
            if (predict_address(reset_rows[i].w) !== reset_rows[i].exp_word) begin
                $display("%0t: table row %0d expected %h actual %h", $time, i,
                         reset_rows[i].exp_word, predict_address(reset_rows[i].w));
                errors++;
            end
            send_word(reset_rows[i].w, 1'b0);
        end
        drain();

        // dense 3-axis view, max base, then extremes with zero sizes and wrap, then rank 2 and rank 1
        set_view(2'd3, 16'd4, 16'd5, 16'd6, 32'd30, 32'd6, 32'd1, 31'h7fffffff);
        view_rows.push_back('{'{sag_pkg::OP_RAVEL, 31'd119, 16'd0, 16'd0, 16'd0},
                              1'b0, '0});
        view_rows.push_back('{'{sag_pkg::OP_RAVEL, 31'h7fffffff, 16'd0, 16'd0, 16'd0},
                              1'b0, '0});
        view_rows.push_back('{'{sag_pkg::OP_COORD, 31'd0, 16'hffff, 16'hffff, 16'hffff},
                              1'b0, '0});
        view_rows.push_back('{'{sag_pkg::OP_INDEX, 31'd0, 16'd3, 16'd4, 16'd5},
                              1'b0, '0});
        view_rows.push_back('{'{sag_pkg::OP_INDEX, 31'd0, 16'hffff, 16'hffff, 16'hffff},
                              1'b0, '0});
        view_rows.push_back('{'{sag_pkg::OP_NONE, 31'd7, 16'd1, 16'd1, 16'd1},
                              1'b0, '0});
        foreach (view_rows[i]) send_word(view_rows[i].w, 1'b0);
        drain();
        set_view(2'd3, 16'd0, 16'hffff, 16'd0, 32'h80000000, 32'h7fffffff,
                 32'hffffffff, 31'd0);
        foreach (view_rows[i]) send_word(view_rows[i].w, 1'b0);
        view_rows[0].w.opcode = sag_pkg::OP_RAVEL;
        drain();
        set_view(2'd2, 16'hffff, 16'd1, 16'd3, 32'd1, 32'd1, 32'd0, 31'd12);
        foreach (view_rows[i]) send_word(view_rows[i].w, 1'b0);
        drain();
        write_reg(sag_pkg::REG_RANK, 32'd1);
        foreach (view_rows[i]) send_word(view_rows[i].w, 1'b0);
        drain();

        // random phases with random views; idling pattern swapped from phase 5, off from phase 10
        for (int ph = 0; ph < 14; ph++) begin
            int nsz;
            logic [15:0] s[3];
            if (ph == 5) begin send_idle_pct = 64; recv_idle_pct = 18; end
            if (ph == 10) begin send_idle_pct = 0; recv_idle_pct = 0; end
            nsz = ($urandom_range(3) == 0) ? 65535 : 12;
            foreach (s[k]) s[k] = 16'($urandom_range(nsz));
            if ($urandom_range(1)) begin
                set_view(2'($urandom_range(3)), s[0], s[1], s[2],
                         32'((s[1] == 0 ? 1 : s[1]) * (s[2] == 0 ? 1 : s[2])),
                         32'(s[2] == 0 ? 1 : s[2]), 32'd1, 31'($urandom));
            end else begin
                set_view(2'($urandom_range(3)), s[0], s[1], s[2], $urandom,
                         32'($signed(5'($urandom))), $urandom, 31'($urandom));
            end
            if (ph == 3) begin
                // long stall on the receive side so the pipe fills and backs up
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (200) @(negedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 14; n++) begin
                send_word(rand_word(nsz == 12 ? 14 : 65535), 1'b1);
                if (n == 40) begin
                    in_ch.valid <= 1'b0;
                    @(negedge i_clk);
                    while (addr_queue.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("strided_array_address_generator_top_tb: PASS");
        else
            $display("strided_array_address_generator_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/sag_pkg.sv
rtl/sag_if.sv
rtl/sag_cfg.sv
rtl/sag_divstage.sv
rtl/sag_pipe.sv
rtl/strided_array_address_generator_top.sv
rtl/sag_checker.sv
tb/sv/strided_array_address_generator_top_tb.sv
